// ===== rtl/core/bcf_pkg.sv =====
// ----------------------------------------------------------------------------
// Beacon command filter package
// Payload types, offsets and header constants shared by the filter modules.
// ----------------------------------------------------------------------------
package bcf_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] REG_UUID_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_UUID_LOW  = 1'b1;

    // Structure layout, counted in bytes after the length byte.
    localparam logic [7:0] VENDOR_TYPE    = 8'hFF;
    localparam logic [7:0] MIN_BEACON_LEN = 8'd25;
    localparam logic [7:0] OFF_TYPE       = 8'd0;
    localparam logic [7:0] OFF_UUID_FIRST = 8'd5;
    localparam logic [7:0] OFF_CMD        = 8'd21;
    localparam logic [7:0] OFF_MASK       = 8'd22;
    localparam logic [7:0] OFF_MODE       = 8'd23;

    // Input request: one payload byte.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    // Output request: flags at the end of a packet.
    typedef struct packed {
        logic [3:0] sensor_mask;
        logic       continuous_mode;
        logic       sensor_request;
        logic       beacon_matched;
    } t_out_item;

    // Expected vendor header bytes 4C 00 02 15.
    function automatic logic [7:0] hdr_byte(input logic [1:0] sel);
        logic [7:0] val;
        unique case (sel)
            2'd0:    val = 8'h4C;
            2'd1:    val = 8'h00;
            2'd2:    val = 8'h02;
            default: val = 8'h15;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/core/bcf_stream_if.sv =====
// ----------------------------------------------------------------------------
// Beacon command filter stream interface
// Valid/ready channel carrying one payload of type T per request.
// ----------------------------------------------------------------------------
interface bcf_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/bcf_uuid_regs.sv =====
// ----------------------------------------------------------------------------
// Beacon command filter UUID registers
// Holds the expected 16-byte UUID written through the configuration port.
// ----------------------------------------------------------------------------
module bcf_uuid_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bcf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bcf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic [15:0][7:0]               o_uuid
);

    logic [63:0] r_uuid_high;
    logic [63:0] r_uuid_low;

    // Register decode; first UUID byte sits in the top byte of the high word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uuid_high <= '0;
            r_uuid_low  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bcf_pkg::REG_UUID_HIGH: r_uuid_high <= i_cfg_data;
                bcf_pkg::REG_UUID_LOW:  r_uuid_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Byte 0 of the UUID lands in element 15.
    assign o_uuid = {r_uuid_high, r_uuid_low};

endmodule

// ===== rtl/core/bcf_parser.sv =====
// ----------------------------------------------------------------------------
// Beacon command filter parser
// Walks length/type structures one byte per step and applies qualifying
// beacon commands to the persistent node flags.
// ----------------------------------------------------------------------------
module bcf_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  bcf_pkg::t_in_item  i_item,
    input  logic [15:0][7:0]   i_uuid,
    output bcf_pkg::t_out_item o_result
);

    // Per-packet parse state.
    logic       r_expect;
    logic       r_stopped;
    logic [7:0] r_length;
    logic [7:0] r_offset;
    logic       r_vendor;
    logic       r_hdr_ok;
    logic [1:0] r_cmd;
    logic [3:0] r_mask;
    logic [2:0] r_mode;
    logic       r_request;
    logic       r_match;
    // Persistent flags: bits 3..0 sensor mask, bit 4 continuous mode.
    logic [4:0] r_flags;

    logic       n_expect;
    logic       n_stopped;
    logic [7:0] n_length;
    logic [7:0] n_offset;
    logic       n_vendor;
    logic       n_hdr_ok;
    logic [1:0] n_cmd;
    logic [3:0] n_mask;
    logic [2:0] n_mode;
    logic       n_request;
    logic       n_match;
    logic [4:0] n_flags;

    logic [7:0] uuid_off;
    logic [8:0] off_inc;
    logic [7:0] b;

    assign b        = i_item.data_byte;
    assign uuid_off = r_offset - bcf_pkg::OFF_UUID_FIRST;
    assign off_inc  = {1'b0, r_offset} + 9'd1;

    // Next-state logic for one accepted byte.
    always_comb begin
        n_expect  = r_expect;
        n_stopped = r_stopped;
        n_length  = r_length;
        n_offset  = r_offset;
        n_vendor  = r_vendor;
        n_hdr_ok  = r_hdr_ok;
        n_cmd     = r_cmd;
        n_mask    = r_mask;
        n_mode    = r_mode;
        n_request = r_request;
        n_match   = r_match;
        n_flags   = r_flags;
        o_result  = '0;

        if (i_step) begin
            if (!r_stopped) begin
                if (r_expect) begin
                    // Length byte: zero ends parsing for the rest of the packet.
                    if (b == 8'd0) begin
                        n_stopped = 1'b1;
                    end else begin
                        n_length = b;
                        n_offset = '0;
                        n_vendor = 1'b0;
                        n_hdr_ok = 1'b1;
                        n_cmd    = '0;
                        n_mask   = '0;
                        n_mode   = '0;
                        n_expect = 1'b0;
                    end
                end else begin
                    // Body byte: type, header, UUID or command fields.
                    if (r_offset == bcf_pkg::OFF_TYPE) begin
                        n_vendor = (b == bcf_pkg::VENDOR_TYPE);
                    end else if (r_offset < bcf_pkg::OFF_UUID_FIRST) begin
                        if (b != bcf_pkg::hdr_byte(r_offset[1:0] - 2'd1)) begin
                            n_hdr_ok = 1'b0;
                        end
                    end else if (r_offset < bcf_pkg::OFF_CMD) begin
                        if (b != i_uuid[~uuid_off[3:0]]) begin
                            n_hdr_ok = 1'b0;
                        end
                    end else if (r_offset == bcf_pkg::OFF_CMD) begin
                        n_cmd = b[1:0];
                    end else if (r_offset == bcf_pkg::OFF_MASK) begin
                        n_mask = b[3:0];
                    end else if (r_offset == bcf_pkg::OFF_MODE) begin
                        n_mode = b[2:0];
                    end

                    if (off_inc >= {1'b0, r_length}) begin
                        // Structure complete: apply it if it qualifies.
                        if (n_vendor && n_hdr_ok && (r_length >= bcf_pkg::MIN_BEACON_LEN)) begin
                            n_match = 1'b1;
                            if (n_cmd[0]) begin
                                n_flags[3:0] = n_mask;
                                n_request    = 1'b1;
                            end
                            if (n_cmd[1]) begin
                                if (n_mode[0]) begin
                                    n_flags[4] = ~n_flags[4];
                                end else if (n_mode[1]) begin
                                    n_flags[4] = 1'b0;
                                end else if (n_mode[2]) begin
                                    n_flags[4] = 1'b1;
                                end
                            end
                        end
                        n_expect = 1'b1;
                        n_offset = '0;
                    end else begin
                        n_offset = off_inc[7:0];
                    end
                end
            end

            // End of packet: report the flags and clear per-packet state.
            if (i_item.last_byte) begin
                o_result.sensor_mask     = n_flags[3:0];
                o_result.continuous_mode = n_flags[4];
                o_result.sensor_request  = n_request;
                o_result.beacon_matched  = n_match;
                n_expect  = 1'b1;
                n_stopped = 1'b0;
                n_length  = '0;
                n_offset  = '0;
                n_vendor  = 1'b0;
                n_hdr_ok  = 1'b0;
                n_cmd     = '0;
                n_mask    = '0;
                n_mode    = '0;
                n_request = 1'b0;
                n_match   = 1'b0;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect  <= 1'b1;
            r_stopped <= 1'b0;
            r_length  <= '0;
            r_offset  <= '0;
            r_vendor  <= 1'b0;
            r_hdr_ok  <= 1'b0;
            r_cmd     <= '0;
            r_mask    <= '0;
            r_mode    <= '0;
            r_request <= 1'b0;
            r_match   <= 1'b0;
            r_flags   <= '0;
        end else begin
            r_expect  <= n_expect;
            r_stopped <= n_stopped;
            r_length  <= n_length;
            r_offset  <= n_offset;
            r_vendor  <= n_vendor;
            r_hdr_ok  <= n_hdr_ok;
            r_cmd     <= n_cmd;
            r_mask    <= n_mask;
            r_mode    <= n_mode;
            r_request <= n_request;
            r_match   <= n_match;
            r_flags   <= n_flags;
        end
    end

`ifndef ASSERT_OFF
    // A stopped packet waits for its end with the length flag still set.
    a_stop_expect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> r_expect)
        else $error("parse stopped outside a length position");

    // A request can only come from a qualifying structure.
    a_request_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_request |-> r_match)
        else $error("sensor request without a matched beacon");

    // The last byte of a packet leaves the per-packet state cleared.
    a_packet_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.last_byte |=> r_expect && !r_stopped && !r_match && !r_request)
        else $error("per-packet state not cleared at packet end");
`endif

endmodule

// ===== rtl/core/beacon_command_filter_top.sv =====
// ----------------------------------------------------------------------------
// Beacon command filter top level
// Registers each payload byte, parses it in a single pass and holds the
// end-of-packet flags in an output register.
// ----------------------------------------------------------------------------
// A byte accepted into the input register is parsed from there; a last byte's
// result is loaded into the output register and presented on o_flags.
// Throughput: one byte per cycle, set by the single input register stage;
// a last byte waits only while the output register still holds a result.
// Reset: synchronous active-low i_rst_n clears UUID, flags and parse state.
module beacon_command_filter_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bcf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bcf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bcf_stream_if.sink                     i_byte,
    bcf_stream_if.source                   o_flags
);

    logic               r_in_valid;
    bcf_pkg::t_in_item  r_in_item;
    logic               r_out_valid;
    bcf_pkg::t_out_item r_out_item;

    logic               consume;
    logic               in_ready;
    logic               out_free;
    logic [15:0][7:0]   uuid;
    bcf_pkg::t_out_item result;

    // A held byte moves on unless it ends a packet and the result slot is busy.
    assign out_free = !r_out_valid || o_flags.ready;
    assign consume  = r_in_valid && (!r_in_item.last_byte || out_free);
    assign in_ready = !r_in_valid || consume;

    assign i_byte.ready  = in_ready;
    assign o_flags.valid = r_out_valid;
    assign o_flags.data  = r_out_item;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_byte.valid) begin
            r_in_item <= i_byte.data;
        end
    end

    bcf_uuid_regs u_uuid_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_uuid      (uuid)
    );

    bcf_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (consume),
        .i_item   (r_in_item),
        .i_uuid   (uuid),
        .o_result (result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && r_in_item.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_flags.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && r_in_item.last_byte) begin
            r_out_item <= result;
        end
    end

`ifndef ASSERT_OFF
    // Input stalls only for a packet end blocked by a pending result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> r_in_valid && r_in_item.last_byte && r_out_valid && !o_flags.ready)
        else $error("input stalled without a blocked packet end");

    // Every parsed packet end produces a pending result.
    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && r_in_item.last_byte |=> r_out_valid)
        else $error("packet end did not load the output register");

    // A held byte that is not parsed stays in the input register.
    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !consume |=> r_in_valid && $stable(r_in_item))
        else $error("held input byte lost or changed");
`endif

endmodule
